FILE: hdl/binary_frame_parser_fletcher8_macros.svh
// assertion macros used by the frame parser rtl
`ifndef BINARY_FRAME_PARSER_FLETCHER8_MACROS_SVH
`define BINARY_FRAME_PARSER_FLETCHER8_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bfp_pkg.sv
// types, codes and helper function of the frame parser
`default_nettype none

package bfp_pkg;

    typedef logic [1:0] t_event;
    typedef logic [1:0] t_kind;

    // parser phase
    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_CLASS   = 3'd2,
        PH_ID      = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_LEN_HI  = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_CHECK   = 3'd7
    } t_phase;

    // control of the running checksum unit
    typedef struct packed {
        logic clear;
        logic add;
        logic xor_ck;
    } t_sum_ctl;

    localparam logic [7:0] SYNC_FIRST   = 8'hB5;
    localparam logic [7:0] SYNC_SECOND  = 8'h62;
    localparam logic [7:0] CLS_NAV      = 8'h01;
    localparam logic [7:0] CLS_RXM      = 8'h02;
    localparam logic [7:0] ID_NAV_PVT   = 8'h07;
    localparam logic [7:0] ID_RXM_RAW   = 8'h15;
    localparam logic [7:0] ID_RXM_SFRBX = 8'h13;

    localparam t_event EV_NONE    = 2'd0;
    localparam t_event EV_PAYLOAD = 2'd1;
    localparam t_event EV_GOOD    = 2'd2;
    localparam t_event EV_CK_ERR  = 2'd3;

    localparam t_kind KIND_UNKNOWN = 2'd0;
    localparam t_kind KIND_NAV_PVT = 2'd1;
    localparam t_kind KIND_RXM_RAW = 2'd2;
    localparam t_kind KIND_RXM_SFR = 2'd3;

    // frame kind from class and id
    function automatic t_kind kind_of(input logic [7:0] cls, input logic [7:0] id);
        t_kind k;
        k = KIND_UNKNOWN;
        if (cls == CLS_NAV && id == ID_NAV_PVT) begin
            k = KIND_NAV_PVT;
        end else if (cls == CLS_RXM && id == ID_RXM_RAW) begin
            k = KIND_RXM_RAW;
        end else if (cls == CLS_RXM && id == ID_RXM_SFRBX) begin
            k = KIND_RXM_SFR;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bfp_if.sv
// valid/ready channel interfaces for received bytes and parser results
`default_nettype none

interface bfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface bfp_out_if;
    logic                 valid;
    logic                 ready;
    bfp_pkg::t_event      event_res;
    logic [7:0]           payload_byte;
    logic [15:0]          payload_index;
    logic [7:0]           message_class;
    logic [7:0]           message_id;
    logic [15:0]          payload_length;
    bfp_pkg::t_kind       frame_kind;

    modport source (
        output valid, output event_res, output payload_byte, output payload_index,
        output message_class, output message_id, output payload_length,
        output frame_kind, input ready
    );
    modport sink (
        input valid, input event_res, input payload_byte, input payload_index,
        input message_class, input message_id, input payload_length,
        input frame_kind, output ready
    );
endinterface

`default_nettype wire

FILE: hdl/binary_frame_parser_fletcher8.sv
// top level of the sync/header/payload/checksum frame parser
//
// One received byte per transaction, one result transaction per byte. The parser
// hunts for 0xB5 0x62, takes class, id and a little-endian length, passes payload
// bytes out with their index and closes each frame with a good or checksum-error
// verdict carrying class, id, length and frame kind. The phase, counter and
// fletcher sums update in the cycle the byte is taken and the result lands in an
// output register, so a byte can enter in every cycle. The result of an input
// transaction is valid in the next cycle. Input ready drops only while a
// registered result is held by a stalled sink.
`default_nettype none

`include "binary_frame_parser_fletcher8_macros.svh"

module binary_frame_parser_fletcher8 (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bfp_in_if.sink     i_in,
    bfp_out_if.source  o_out
);
    import bfp_pkg::*;

    // parser state
    t_phase      r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [15:0] r_len,   n_len;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id,    n_id;

    // result register
    logic        r_out_valid;
    t_event      r_event;
    logic [7:0]  r_pbyte;
    logic [15:0] r_pindex;
    logic [7:0]  r_oclass;
    logic [7:0]  r_oid;
    logic [15:0] r_olen;
    t_kind       r_okind;

    // result of the byte being taken
    t_event      res_event;
    logic [7:0]  res_pbyte;
    logic [15:0] res_pindex;
    logic        res_header;

    t_sum_ctl    ctl_raw, sum_ctl;
    logic [7:0]  sum_a, sum_b;
    logic [7:0]  b;
    logic        in_ready;
    logic        in_fire;

    assign b        = i_in.data_byte;
    assign in_ready = !r_out_valid || o_out.ready;
    assign in_fire  = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // next state and result for one byte
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_len      = r_len;
        n_class    = r_class;
        n_id       = r_id;
        ctl_raw    = '0;
        res_event  = EV_NONE;
        res_pbyte  = 8'h00;
        res_pindex = 16'h0000;
        res_header = 1'b0;
        case (r_phase)
            PH_SYNC1: begin
                if (b == SYNC_FIRST) n_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b == SYNC_SECOND)     n_phase = PH_CLASS;
                else if (b == SYNC_FIRST) n_phase = PH_SYNC2;
                else                      n_phase = PH_SYNC1;
            end
            PH_CLASS: begin
                ctl_raw.clear = 1'b1;
                ctl_raw.add   = 1'b1;
                n_class       = b;
                n_phase       = PH_ID;
            end
            PH_ID: begin
                ctl_raw.add = 1'b1;
                n_id        = b;
                n_phase     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                ctl_raw.add = 1'b1;
                n_len       = {8'h00, b};
                n_phase     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                ctl_raw.add = 1'b1;
                n_len       = {b, r_len[7:0]};
                n_count     = 16'h0000;
                // empty payload goes straight to the checksum bytes
                n_phase     = (n_len == 16'h0000) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                ctl_raw.add = 1'b1;
                res_event   = EV_PAYLOAD;
                res_pbyte   = b;
                res_pindex  = r_count;
                res_header  = 1'b1;
                n_count     = r_count + 16'd1;
                if (n_count >= r_len) begin
                    n_count = 16'h0000;
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (r_count == 16'h0000) begin
                    ctl_raw.xor_ck = 1'b1;
                    n_count        = 16'd1;
                end else begin
                    res_event  = (sum_a == 8'h00 && sum_b == b) ? EV_GOOD : EV_CK_ERR;
                    res_header = 1'b1;
                    n_count    = 16'h0000;
                    n_phase    = PH_SYNC1;
                end
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
    end

    assign sum_ctl = in_fire ? ctl_raw : '0;

    bfp_fletcher u_fletcher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sum_ctl),
        .i_byte  (b),
        .o_sum_a (sum_a),
        .o_sum_b (sum_b)
    );

    // state registers advance on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_count <= 16'h0000;
            r_len   <= 16'h0000;
            r_class <= 8'h00;
            r_id    <= 8'h00;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len   <= n_len;
            r_class <= n_class;
            r_id    <= n_id;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_event  <= res_event;
            r_pbyte  <= res_pbyte;
            r_pindex <= res_pindex;
            r_oclass <= res_header ? r_class : 8'h00;
            r_oid    <= res_header ? r_id : 8'h00;
            r_olen   <= res_header ? r_len : 16'h0000;
            r_okind  <= res_header ? kind_of(r_class, r_id) : KIND_UNKNOWN;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_res      = r_event;
    assign o_out.payload_byte   = r_pbyte;
    assign o_out.payload_index  = r_pindex;
    assign o_out.message_class  = r_oclass;
    assign o_out.message_id     = r_oid;
    assign o_out.payload_length = r_olen;
    assign o_out.frame_kind     = r_okind;

    // checks
    `BFP_ASSERT_NEXT(a_payload_event, i_clk, i_rst_n, in_fire && r_phase == PH_PAYLOAD,
        r_out_valid && r_event == EV_PAYLOAD, "payload byte did not yield payload event")
    `BFP_ASSERT_NOW(a_none_no_header, i_clk, i_rst_n, r_out_valid && r_event == EV_NONE,
        r_olen == 16'h0000 && r_okind == KIND_UNKNOWN, "header fields set on empty result")
    `BFP_ASSERT_NOW(a_check_count, i_clk, i_rst_n, r_phase == PH_CHECK,
        r_count <= 16'd1, "checksum byte index out of range")
    `BFP_ASSERT_NEXT(a_hunt_exit, i_clk, i_rst_n, in_fire && r_phase == PH_SYNC1,
        r_phase == PH_SYNC1 || r_phase == PH_SYNC2, "left hunting without sync byte")

endmodule

`default_nettype wire

FILE: hdl/bfp_fletcher.sv
// running 8-bit fletcher sums with checksum-a fold
`default_nettype none

module bfp_fletcher (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire bfp_pkg::t_sum_ctl i_ctl,
    input  wire [7:0]           i_byte,
    output logic [7:0]          o_sum_a,
    output logic [7:0]          o_sum_b
);
    import bfp_pkg::*;

    logic [7:0] r_sum_a, n_sum_a;
    logic [7:0] r_sum_b, n_sum_b;
    logic [7:0] base_a, base_b;

    // clear restarts the sums on the class byte
    always_comb begin
        base_a  = i_ctl.clear ? 8'h00 : r_sum_a;
        base_b  = i_ctl.clear ? 8'h00 : r_sum_b;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        if (i_ctl.add) begin
            n_sum_a = base_a + i_byte;
            n_sum_b = base_b + n_sum_a;
        end else if (i_ctl.xor_ck) begin
            // zero exactly when ck_a matches
            n_sum_a = r_sum_a ^ i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= 8'h00;
            r_sum_b <= 8'h00;
        end else begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

    assign o_sum_a = r_sum_a;
    assign o_sum_b = r_sum_b;

endmodule

`default_nettype wire
